@@ hdl/csc_pkg.sv @@
// Shared types, constants and arithmetic helpers of the climate sensor compensation block.
`default_nettype none

package csc_pkg;

	typedef logic signed [31:0] word_t;

	localparam int DIV_W = 32;

	localparam logic [2:0] CFG_TEMP       = 3'd0;
	localparam logic [2:0] CFG_PRESS_LOW  = 3'd1;
	localparam logic [2:0] CFG_PRESS_HIGH = 3'd2;
	localparam logic [2:0] CFG_PRESS_HUM  = 3'd3;
	localparam logic [2:0] CFG_HUM_TAIL   = 3'd4;

	localparam word_t TEMP_MIN    = -32'sd4000;
	localparam word_t TEMP_MAX    = 32'sd8500;
	localparam logic [31:0] PRESS_MIN = 32'd30000;
	localparam logic [31:0] PRESS_MAX = 32'd110000;
	localparam word_t HUM_E_MAX   = 32'sd419430400;
	localparam word_t HUM_MAX     = 32'sd102400;
	localparam word_t P_OFFSET    = 32'sd64000;
	localparam word_t H_OFFSET    = 32'sd76800;
	localparam logic [31:0] P_FULL = 32'd1048576;
	localparam logic [31:0] P_SCALE = 32'd3125;

	typedef struct packed {
		logic [2:0]  measurement_mask;
		logic [19:0] raw_pressure;
		logic [19:0] raw_temperature;
		logic [15:0] raw_humidity;
	} sample_t;

	typedef struct packed {
		logic signed [14:0] temperature_centi;
		logic [16:0]        pressure_pa;
		logic [16:0]        humidity_q10;
	} result_t;

	// Side information that travels beside the pressure divider.
	typedef struct packed {
		logic [2:0]         mask;
		logic               div_zero;
		logic               dbl;
		logic signed [14:0] temp;
		word_t              hum_c;
	} tag_t;

	// Low 32 bits of a product, which is the same for signed and unsigned operands.
	function automatic word_t smul(input word_t a, input word_t b);
		return a * b;
	endfunction

	// Signed division by 2**k with truncation toward zero.
	function automatic word_t sdiv_p2(input word_t x, input logic [4:0] k);
		word_t bias;
		bias = x[31] ? word_t'(~(32'hFFFF_FFFF << k)) : 32'sd0;
		return (x + bias) >>> k;
	endfunction

endpackage

`default_nettype wire

@@ hdl/csc_div.sv @@
// Pipelined unsigned 32-bit restoring divider, one quotient bit per stage.
`default_nettype none

module csc_div (
	input  wire logic        clk,
	input  wire logic [31:0] dividend,
	input  wire logic [31:0] divisor,
	output logic [31:0]      quotient
);
	import csc_pkg::*;

	logic [DIV_W-1:0] rem_q [DIV_W];
	logic [DIV_W-1:0] num_q [DIV_W];
	logic [DIV_W-1:0] den_q [DIV_W];
	logic [DIV_W-1:0] quo_q [DIV_W];

	logic [DIV_W-1:0] pr_rem [DIV_W];
	logic [DIV_W-1:0] pr_num [DIV_W];
	logic [DIV_W-1:0] pr_den [DIV_W];
	logic [DIV_W-1:0] pr_quo [DIV_W];
	logic [DIV_W:0]   diff   [DIV_W];
	logic [DIV_W-1:0] nx_rem [DIV_W];
	logic [DIV_W-1:0] nx_quo [DIV_W];

	always_comb begin
		pr_rem[0] = '0;
		pr_num[0] = dividend;
		pr_den[0] = divisor;
		pr_quo[0] = '0;
		for (int i = 1; i < DIV_W; i++) begin
			pr_rem[i] = rem_q[i-1];
			pr_num[i] = num_q[i-1];
			pr_den[i] = den_q[i-1];
			pr_quo[i] = quo_q[i-1];
		end
		for (int i = 0; i < DIV_W; i++) begin
			diff[i] = {pr_rem[i], pr_num[i][DIV_W-1]} - {1'b0, pr_den[i]};
			if (!diff[i][DIV_W]) begin
				nx_rem[i] = diff[i][DIV_W-1:0];
			end else begin
				nx_rem[i] = {pr_rem[i][DIV_W-2:0], pr_num[i][DIV_W-1]};
			end
			nx_quo[i] = {pr_quo[i][DIV_W-2:0], ~diff[i][DIV_W]};
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < DIV_W; i++) begin
			rem_q[i] <= nx_rem[i];
			num_q[i] <= {pr_num[i][DIV_W-2:0], 1'b0};
			den_q[i] <= pr_den[i];
			quo_q[i] <= nx_quo[i];
		end
	end

	assign quotient = quo_q[DIV_W-1];

endmodule

`default_nettype wire

@@ hdl/climate_sensor_compensation_top.sv @@
// Top level of the climate sensor compensation pipeline with its calibration registers.
`default_nettype none

// Usage
// The block turns one raw sample (pressure, temperature, humidity and a mask
// of wanted quantities) into compensated temperature, pressure and humidity.
// A sample transaction is taken at a rising edge where start is high and busy
// is low. busy never rises: the datapath is a fixed pipeline that takes one
// sample in every cycle, so the throughput is one transaction per clock.
// Each sample yields exactly one result transaction, shown on result for one
// cycle with result_valid high. The sample passes through a pipeline made
// of the pressure divider, a 32-stage restoring divider producing one
// quotient bit per stage, with eleven stages of multipliers ahead of it and
// three behind it, the last of which is the result register. The receiver
// cannot stall the block; results leave in the order in which samples arrived.
// Calibration coefficients are written through cfg_we, cfg_index and
// cfg_data, one register per cycle; writes to indexes past the last register
// are ignored. Coefficients must only change while no sample is in flight.
// Reset clears all calibration registers to zero and empties the pipeline.

module climate_sensor_compensation_top (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire csc_pkg::sample_t  sample,
	output logic                   result_valid,
	output csc_pkg::result_t       result,
	input  wire logic              cfg_we,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [63:0]       cfg_data
);
	import csc_pkg::*;

	localparam int LATENCY = 14 + DIV_W;

	// Calibration registers.
	logic [47:0] temp_coeffs_q;
	logic [63:0] press_low_q;
	logic [63:0] press_high_q;
	logic [47:0] press_hum_q;
	logic [31:0] hum_tail_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_coeffs_q <= '0;
			press_low_q   <= '0;
			press_high_q  <= '0;
			press_hum_q   <= '0;
			hum_tail_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TEMP:       temp_coeffs_q <= cfg_data[47:0];
				CFG_PRESS_LOW:  press_low_q   <= cfg_data;
				CFG_PRESS_HIGH: press_high_q  <= cfg_data;
				CFG_PRESS_HUM:  press_hum_q   <= cfg_data[47:0];
				CFG_HUM_TAIL:   hum_tail_q    <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// Coefficients widened to 32-bit signed words.
	word_t t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, h1, h2, h3, h5, h6;
	word_t h4_shl;
	assign t1 = {16'd0, temp_coeffs_q[15:0]};
	assign t2 = {{16{temp_coeffs_q[31]}}, temp_coeffs_q[31:16]};
	assign t3 = {{16{temp_coeffs_q[47]}}, temp_coeffs_q[47:32]};
	assign p1 = {16'd0, press_low_q[15:0]};
	assign p2 = {{16{press_low_q[31]}}, press_low_q[31:16]};
	assign p3 = {{16{press_low_q[47]}}, press_low_q[47:32]};
	assign p4 = {{16{press_low_q[63]}}, press_low_q[63:48]};
	assign p5 = {{16{press_high_q[15]}}, press_high_q[15:0]};
	assign p6 = {{16{press_high_q[31]}}, press_high_q[31:16]};
	assign p7 = {{16{press_high_q[47]}}, press_high_q[47:32]};
	assign p8 = {{16{press_high_q[63]}}, press_high_q[63:48]};
	assign p9 = {{16{press_hum_q[15]}}, press_hum_q[15:0]};
	assign h1 = {24'd0, press_hum_q[23:16]};
	assign h2 = {{16{press_hum_q[39]}}, press_hum_q[39:24]};
	assign h3 = {24'd0, press_hum_q[47:40]};
	// H4 only ever appears multiplied by 2**20, which keeps its low 12 bits.
	assign h4_shl = {hum_tail_q[11:0], 20'd0};
	assign h5 = {{20{hum_tail_q[23]}}, hum_tail_q[23:12]};
	assign h6 = {{24{hum_tail_q[31]}}, hum_tail_q[31:24]};

	assign busy = 1'b0;

	// Valid bits of the stages ahead of the divider.
	logic [11:1] v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[10:1], start};
		end
	end

	// Stage 1: fine temperature offsets.
	logic [2:0]  mask_s1;
	logic [19:0] rp_s1;
	logic [15:0] rh_s1;
	word_t       ta_s1, tb_s1;

	always_ff @(posedge clk) begin
		mask_s1 <= sample.measurement_mask;
		rp_s1   <= sample.raw_pressure;
		rh_s1   <= sample.raw_humidity;
		ta_s1   <= word_t'({15'd0, sample.raw_temperature[19:3]}) - (t1 <<< 1);
		tb_s1   <= word_t'({16'd0, sample.raw_temperature[19:4]}) - t1;
	end

	// Stage 2: the two temperature products.
	logic [2:0]  mask_s2;
	logic [19:0] rp_s2;
	logic [15:0] rh_s2;
	word_t       tma_s2, tmb_s2;

	always_ff @(posedge clk) begin
		mask_s2 <= mask_s1;
		rp_s2   <= rp_s1;
		rh_s2   <= rh_s1;
		tma_s2  <= smul(ta_s1, t2);
		tmb_s2  <= smul(tb_s1, tb_s1);
	end

	// Stage 3: scale the linear term, weight the square term by T3.
	logic [2:0]  mask_s3;
	logic [19:0] rp_s3;
	logic [15:0] rh_s3;
	word_t       ta_s3, tmb_s3;

	always_ff @(posedge clk) begin
		mask_s3 <= mask_s2;
		rp_s3   <= rp_s2;
		rh_s3   <= rh_s2;
		ta_s3   <= sdiv_p2(tma_s2, 5'd11);
		tmb_s3  <= smul(sdiv_p2(tmb_s2, 5'd12), t3);
	end

	// Stage 4: fine temperature.
	logic [2:0]  mask_s4;
	logic [19:0] rp_s4;
	logic [15:0] rh_s4;
	word_t       tf_s4;

	always_ff @(posedge clk) begin
		mask_s4 <= mask_s3;
		rp_s4   <= rp_s3;
		rh_s4   <= rh_s3;
		tf_s4   <= ta_s3 + sdiv_p2(tmb_s3, 5'd14);
	end

	// Stage 5: temperature product and the offsets used by pressure and humidity.
	logic [2:0]  mask_s5;
	logic [19:0] rp_s5;
	logic [15:0] rh_s5;
	word_t       tf5_s5, pa_s5, ha_s5;

	always_ff @(posedge clk) begin
		mask_s5 <= mask_s4;
		rp_s5   <= rp_s4;
		rh_s5   <= rh_s4;
		tf5_s5  <= smul(tf_s4, 32'sd5);
		pa_s5   <= sdiv_p2(tf_s4, 5'd1) - P_OFFSET;
		ha_s5   <= tf_s4 - H_OFFSET;
	end

	// Stage 6: clamped temperature, first pressure and humidity products.
	word_t temp_w;
	word_t pq_w;
	always_comb begin
		temp_w = sdiv_p2(tf5_s5 + 32'sd128, 5'd8);
		if (temp_w < TEMP_MIN) begin
			temp_w = TEMP_MIN;
		end else if (temp_w > TEMP_MAX) begin
			temp_w = TEMP_MAX;
		end
		pq_w = sdiv_p2(pa_s5, 5'd2);
	end

	logic [2:0]         mask_s6;
	logic [19:0]        rp_s6;
	logic signed [14:0] temp_s6;
	word_t              pq2_s6, pa5_s6, pd_s6, he_s6, hb_s6, hc_s6;

	always_ff @(posedge clk) begin
		mask_s6 <= mask_s5;
		rp_s6   <= rp_s5;
		temp_s6 <= temp_w[14:0];
		pq2_s6  <= smul(pq_w, pq_w);
		pa5_s6  <= smul(pa_s5, p5);
		pd_s6   <= smul(p2, pa_s5);
		he_s6   <= word_t'({2'd0, rh_s5, 14'd0}) - h4_shl - smul(h5, ha_s5) + 32'sd16384;
		hb_s6   <= smul(ha_s5, h6);
		hc_s6   <= smul(ha_s5, h3);
	end

	// Stage 7.
	logic [2:0]         mask_s7;
	logic [19:0]        rp_s7;
	logic signed [14:0] temp_s7;
	word_t              pb_s7, pc_s7, pd_s7, pa5_s7, he_s7, hb_s7, hc_s7;

	always_ff @(posedge clk) begin
		mask_s7 <= mask_s6;
		rp_s7   <= rp_s6;
		temp_s7 <= temp_s6;
		pb_s7   <= smul(sdiv_p2(pq2_s6, 5'd11), p6);
		pc_s7   <= smul(p3, sdiv_p2(pq2_s6, 5'd13));
		pd_s7   <= sdiv_p2(pd_s6, 5'd1);
		pa5_s7  <= pa5_s6 <<< 1;
		he_s7   <= sdiv_p2(he_s6, 5'd15);
		hb_s7   <= sdiv_p2(hb_s6, 5'd10);
		hc_s7   <= sdiv_p2(hc_s6, 5'd11);
	end

	// Stage 8.
	logic [2:0]         mask_s8;
	logic [19:0]        rp_s8;
	logic signed [14:0] temp_s8;
	word_t              pb_s8, pa_s8, hm_s8, he_s8;

	always_ff @(posedge clk) begin
		mask_s8 <= mask_s7;
		rp_s8   <= rp_s7;
		temp_s8 <= temp_s7;
		pb_s8   <= sdiv_p2(pb_s7 + pa5_s7, 5'd2) + (p4 <<< 16);
		pa_s8   <= 32'sd32768 + sdiv_p2(sdiv_p2(pc_s7, 5'd3) + pd_s7, 5'd18);
		hm_s8   <= smul(hb_s7, hc_s7 + 32'sd32768);
		he_s8   <= he_s7;
	end

	// Stage 9.
	logic [2:0]         mask_s9;
	logic signed [14:0] temp_s9;
	word_t              pm_s9, hd_s9, he_s9;
	logic [31:0]        pr_s9;

	always_ff @(posedge clk) begin
		mask_s9 <= mask_s8;
		temp_s9 <= temp_s8;
		pm_s9   <= smul(pa_s8, p1);
		pr_s9   <= P_FULL - {12'd0, rp_s8} - sdiv_p2(pb_s8, 5'd12);
		hd_s9   <= sdiv_p2(hm_s8, 5'd10) + 32'sd2097152;
		he_s9   <= he_s8;
	end

	// Stage 10.
	logic [2:0]         mask_s10;
	logic signed [14:0] temp_s10;
	word_t              pav_s10, hh_s10, he_s10;
	logic [31:0]        prm_s10;

	always_ff @(posedge clk) begin
		mask_s10 <= mask_s9;
		temp_s10 <= temp_s9;
		pav_s10  <= sdiv_p2(pm_s9, 5'd15);
		prm_s10  <= pr_s9 * P_SCALE;
		hh_s10   <= smul(hd_s9, h2);
		he_s10   <= he_s9;
	end

	// Stage 11: divider operands. A dividend with its top bit set is divided
	// unshifted and the quotient doubled afterwards.
	logic [31:0] num_s11, den_s11;
	tag_t        tag_s11;

	always_ff @(posedge clk) begin
		den_s11          <= pav_s10;
		num_s11          <= prm_s10[31] ? prm_s10 : {prm_s10[30:0], 1'b0};
		tag_s11.mask     <= mask_s10;
		tag_s11.div_zero <= (pav_s10 == 32'sd0);
		tag_s11.dbl      <= prm_s10[31];
		tag_s11.temp     <= temp_s10;
		tag_s11.hum_c    <= smul(he_s10, sdiv_p2(hh_s10 + 32'sd8192, 5'd14));
	end

	logic [31:0] quo;

	csc_div u_div (
		.clk      (clk),
		.dividend (num_s11),
		.divisor  (den_s11),
		.quotient (quo)
	);

	// Side information delayed to line up with the divider's quotient.
	tag_t             tag_q  [DIV_W];
	logic [DIV_W-1:0] tagv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tagv_q <= '0;
		end else begin
			tagv_q <= {tagv_q[DIV_W-2:0], v_q[11]};
		end
	end

	always_ff @(posedge clk) begin
		tag_q[0] <= tag_s11;
		for (int i = 1; i < DIV_W; i++) begin
			tag_q[i] <= tag_q[i-1];
		end
	end

	// Stage 12: pressure correction products, humidity square.
	logic [31:0] prq;
	logic [31:0] px8;
	word_t       hq;
	assign prq = tag_q[DIV_W-1].dbl ? {quo[30:0], 1'b0} : quo;
	assign px8 = prq >> 3;
	assign hq  = sdiv_p2(tag_q[DIV_W-1].hum_c, 5'd15);

	logic        v_s12, v_s13;
	tag_t        tag_s12, tag_s13;
	logic [31:0] pr_s12, psq_s12, pr_s13;
	word_t       pbm_s12, hd2_s12, pa_s13, pb_s13, hm1_s13;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s12        <= 1'b0;
			v_s13        <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			v_s12        <= tagv_q[DIV_W-1];
			v_s13        <= v_s12;
			result_valid <= v_s13;
		end
	end

	always_ff @(posedge clk) begin
		tag_s12 <= tag_q[DIV_W-1];
		pr_s12  <= prq;
		psq_s12 <= px8 * px8;
		pbm_s12 <= smul(word_t'(prq >> 2), p8);
		hd2_s12 <= smul(hq, hq);
	end

	// Stage 13.
	always_ff @(posedge clk) begin
		tag_s13 <= tag_s12;
		pr_s13  <= pr_s12;
		pa_s13  <= smul(word_t'(psq_s12 >> 13), p9);
		pb_s13  <= sdiv_p2(pbm_s12, 5'd13);
		hm1_s13 <= smul(sdiv_p2(hd2_s12, 5'd7), h1);
	end

	// Final stage: corrections, clamping and masking into the result register.
	logic [31:0] pres_w;
	word_t       hum_e;
	word_t       hum_w;
	always_comb begin
		pres_w = pr_s13 + sdiv_p2(sdiv_p2(pa_s13, 5'd12) + pb_s13 + p7, 5'd4);
		if (tag_s13.div_zero || pres_w < PRESS_MIN) begin
			pres_w = PRESS_MIN;
		end else if (pres_w > PRESS_MAX) begin
			pres_w = PRESS_MAX;
		end
		hum_e = tag_s13.hum_c - sdiv_p2(hm1_s13, 5'd4);
		if (hum_e < 32'sd0) begin
			hum_e = 32'sd0;
		end else if (hum_e > HUM_E_MAX) begin
			hum_e = HUM_E_MAX;
		end
		hum_w = hum_e >>> 12;
		if (hum_w > HUM_MAX) begin
			hum_w = HUM_MAX;
		end
	end

	always_ff @(posedge clk) begin
		result.temperature_centi <= (tag_s13.mask == 3'd0) ? 15'sd0 : tag_s13.temp;
		result.pressure_pa       <= tag_s13.mask[0] ? pres_w[16:0] : 17'd0;
		result.humidity_q10      <= tag_s13.mask[2] ? hum_w[16:0] : 17'd0;
	end

	// Every accepted sample is followed by a result transaction.
	assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LATENCY result_valid)
		else $error("result transaction missing after sample transaction");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.pressure_pa == 17'd0) ||
			((result.pressure_pa >= 17'd30000) && (result.pressure_pa <= 17'd110000)))
		else $error("pressure outside clamp range");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.temperature_centi >= -15'sd4000) &&
			(result.temperature_centi <= 15'sd8500))
		else $error("temperature outside clamp range");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.humidity_q10 <= 17'd102400))
		else $error("humidity outside clamp range");

endmodule

`default_nettype wire
